// ===== hw/rtl/kea_pkg.sv =====
// Shared types and constants for the key edge and auto-repeat block.
package kea_pkg;

    // Beat types of the two channels.
    typedef struct packed {
        logic [7:0]  key_index;
        logic [15:0] key_sample;
        logic [19:0] time_step_us;
        logic        has_focus;
    } t_key_in;

    typedef struct packed {
        logic repeat_event;
        logic down_edge;
        logic held_level;
        logic up_edge;
        logic idle_level;
    } t_key_out;

    // One entry of the per-key state memory.
    typedef struct packed {
        logic [15:0]        previous_sample;
        logic [15:0]        current_sample;
        logic signed [20:0] hold_timer_us;
        logic               repeat_flag;
    } t_key_entry;

    // Controller to datapath commands.
    typedef struct packed {
        logic clear;    // write reset entry at the sweep address
        logic capture;  // latch the accepted input beat
        logic read;     // read the addressed key entry
        logic update;   // write back and load the output register
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } t_dp_status;

    // Configuration register indexes.
    localparam logic CFG_FIRST_DELAY   = 1'b0;
    localparam logic CFG_REPEAT_PERIOD = 1'b1;

    localparam logic [19:0] FIRST_DELAY_RESET   = 20'd500000;
    localparam logic [19:0] REPEAT_PERIOD_RESET = 20'd50000;

    localparam logic [15:0]        ACTIVE_MASK = 16'h8001;
    localparam logic signed [22:0] TIMER_MAX   = 23'sd1048575;
    localparam logic signed [20:0] TIMER_RESET = -21'sd1000000;

    localparam t_key_entry ENTRY_RESET = '{
        previous_sample: 16'd0,
        current_sample:  16'd0,
        hold_timer_us:   TIMER_RESET,
        repeat_flag:     1'b0
    };

endpackage

// ===== hw/rtl/kea_ctrl.sv =====
// Controller state machine: clearing sweep, input accept, read and update steps.
module kea_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  kea_pkg::t_dp_status i_status,
    output kea_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_cmd.capture = accept;
                if (accept) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = ST_UPDATE;
            end
            ST_UPDATE: begin
                // hold until the output register can take the result
                if (i_status.out_free) begin
                    o_cmd.update = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/kea_datapath.sv =====
// Datapath: per-key state memory, config registers, timer update and output register.
module kea_datapath #(
    parameter int KEY_COUNT = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kea_pkg::t_dp_cmd    i_cmd,
    output kea_pkg::t_dp_status o_status,
    input  kea_pkg::t_key_in    i_in_data,
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_index,
    input  logic [19:0]         i_cfg_data,
    output logic                o_out_valid,
    output kea_pkg::t_key_out   o_out_data,
    input  logic                i_out_stall
);

    localparam int AW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(KEY_COUNT - 1);

    kea_pkg::t_key_entry r_mem [KEY_COUNT];
    kea_pkg::t_key_entry r_rd_data;
    kea_pkg::t_key_entry n_entry;
    kea_pkg::t_key_in    r_in;
    kea_pkg::t_key_out   n_out;

    logic [19:0]        r_first_delay;
    logic [19:0]        r_repeat_period;
    logic [AW-1:0]      r_clr_addr;
    logic [AW+7:0]      idx_ext;
    logic [AW-1:0]      key_addr;
    logic               in_range;
    logic               sample_act;
    logic               prev_act;
    logic               cur_act;
    logic signed [22:0] sum;
    logic signed [22:0] sat;
    logic signed [22:0] fired;
    logic               mem_wr;
    logic [AW-1:0]      mem_wr_addr;
    kea_pkg::t_key_entry mem_wr_data;

    assign idx_ext  = {{AW{1'b0}}, r_in.key_index};
    assign key_addr = idx_ext[AW-1:0];
    assign in_range = (32'(r_in.key_index) < KEY_COUNT);

    assign o_status.clear_last = (r_clr_addr == LAST_ADDR);
    assign o_status.out_free   = !o_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_delay   <= kea_pkg::FIRST_DELAY_RESET;
            r_repeat_period <= kea_pkg::REPEAT_PERIOD_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                kea_pkg::CFG_FIRST_DELAY:   r_first_delay   <= i_cfg_data;
                kea_pkg::CFG_REPEAT_PERIOD: r_repeat_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear && !o_status.clear_last) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in_data;
        end
    end

    // Timer update and edge queries for the addressed key.
    always_comb begin
        sample_act = |(r_in.key_sample & kea_pkg::ACTIVE_MASK);
        sum   = $signed({{2{r_rd_data.hold_timer_us[20]}}, r_rd_data.hold_timer_us})
              + $signed({3'b000, r_in.time_step_us});
        sat   = (sum > kea_pkg::TIMER_MAX) ? kea_pkg::TIMER_MAX : sum;
        fired = sat - $signed({3'b000, r_repeat_period});

        n_entry = r_rd_data;
        if (r_in.has_focus) begin
            n_entry.repeat_flag     = 1'b0;
            n_entry.previous_sample = r_rd_data.current_sample;
            n_entry.current_sample  = r_in.key_sample;
            if (r_rd_data.current_sample == 16'd0 && sample_act) begin
                n_entry.hold_timer_us = '0;
                n_entry.repeat_flag   = 1'b1;
            end else if (sample_act) begin
                if (sat >= $signed({3'b000, r_first_delay})) begin
                    n_entry.hold_timer_us = fired[20:0];
                    n_entry.repeat_flag   = 1'b1;
                end else begin
                    n_entry.hold_timer_us = sat[20:0];
                end
            end
        end

        prev_act = |(n_entry.previous_sample & kea_pkg::ACTIVE_MASK);
        cur_act  = |(n_entry.current_sample & kea_pkg::ACTIVE_MASK);

        n_out.repeat_event = n_entry.repeat_flag;
        n_out.down_edge    = (n_entry.previous_sample == 16'd0) && cur_act;
        n_out.held_level   = prev_act && cur_act;
        n_out.up_edge      = prev_act && (n_entry.current_sample == 16'd0);
        n_out.idle_level   = (n_entry.previous_sample == 16'd0)
                          && (n_entry.current_sample == 16'd0);
        // drop everything for keys outside the table
        if (!in_range) begin
            n_out = '0;
        end
    end

    assign mem_wr      = i_cmd.clear || (i_cmd.update && r_in.has_focus && in_range);
    assign mem_wr_addr = i_cmd.clear ? r_clr_addr : key_addr;
    assign mem_wr_data = i_cmd.clear ? kea_pkg::ENTRY_RESET : n_entry;

    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (i_cmd.read) begin
            r_rd_data <= r_mem[key_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.update) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            o_out_data <= n_out;
        end
    end

endmodule

// ===== hw/rtl/key_edge_and_autorepeat.sv =====
// Top level of the key edge detector with auto-repeat timer.
//
//  channel  | direction | flow control          | beat
//  in       | input     | i_in_valid/o_in_stall | kea_pkg::t_key_in
//  out      | output    | o_out_valid/i_out_stall | kea_pkg::t_key_out
//  cfg      | input     | i_cfg_wr_en           | i_cfg_index, i_cfg_data
//
// Each beat goes through the accept, memory read and update-with-write-back steps;
// the read step comes from the registered read of the per-key state memory.
// After reset a clearing sweep writes every entry with input stalled;
// configuration writes are taken throughout.
// A result waiting in the output register does not block the next accept; the
// update step holds while the output register is full and stalled.
module key_edge_and_autorepeat #(
    parameter int KEY_COUNT = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  kea_pkg::t_key_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output kea_pkg::t_key_out o_out_data,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_index,
    input  logic [19:0]       i_cfg_data
);

    kea_pkg::t_dp_cmd    cmd;
    kea_pkg::t_dp_status status;

    kea_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    kea_datapath #(
        .KEY_COUNT (KEY_COUNT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_in_data),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

// ===== hw/rtl/kea_checker.sv =====
// Port-level checks for the key edge and auto-repeat block, bound to the top level.
module kea_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall
);

    logic in_acc;

    assign in_acc = i_in_valid && !o_in_stall;

    // reset empties the output and stalls the input for the clearing sweep
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_in_stall && !o_out_valid))
        else $error("output valid or input open right after reset");

    a_sweep_first: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> o_in_stall)
        else $error("input open before clearing sweep");

    // one beat at a time: busy for read and update after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall ##1 o_in_stall)
        else $error("input accepted while previous beat in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("stalled output beat dropped");

endmodule

bind key_edge_and_autorepeat kea_checker u_kea_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall)
);
